// ===== rtl/asbe_pkg.sv =====
`default_nettype none

package asbe_pkg;

    // Default geometry of the store
    localparam int DEPTH_DEF = 256;
    localparam int WIDTH_DEF = 32;

    // Position bus width inside the cell row; covers the largest supported depth
    localparam int POS_W = 13;

    // Operation codes
    localparam logic [3:0] OP_PUSH         = 4'd0;
    localparam logic [3:0] OP_POP          = 4'd1;
    localparam logic [3:0] OP_TOP          = 4'd2;
    localparam logic [3:0] OP_GET          = 4'd3;
    localparam logic [3:0] OP_PUT          = 4'd4;
    localparam logic [3:0] OP_SWAP         = 4'd5;
    localparam logic [3:0] OP_REMOVE_AT    = 4'd6;
    localparam logic [3:0] OP_CONTAINS     = 4'd7;
    localparam logic [3:0] OP_REMOVE_VALUE = 4'd8;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    typedef struct packed {
        logic        [3:0]  op;
        logic signed [31:0] item_value;
        logic        [7:0]  index_a;
        logic        [7:0]  index_b;
    } t_req;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic               found;
        logic        [8:0]  count_after;
        logic               is_empty;
        logic        [1:0]  status;
    } t_rsp;

    // What every cell does in the current cycle
    typedef enum logic [2:0] {
        CK_NONE,
        CK_PUSH,
        CK_PUT,
        CK_SWAP,
        CK_REM_AT,
        CK_REM_VAL
    } t_cell_kind;

    typedef struct packed {
        t_cell_kind       kind;
        logic [POS_W-1:0] count;
        logic [POS_W-1:0] ia;
        logic [POS_W-1:0] ib;
        logic [POS_W-1:0] sel_a;
    } t_cell_cmd;

endpackage

`default_nettype wire

// ===== rtl/asbe_cell.sv =====
`default_nettype none

module asbe_cell #(
    parameter int WIDTH = 32,
    parameter int INDEX = 0
) (
    input  wire                    i_clk,
    input  asbe_pkg::t_cell_cmd    i_cmd,
    input  wire  [WIDTH-1:0]       i_val,
    input  wire  [WIDTH-1:0]       i_a_val,
    input  wire  [WIDTH-1:0]       i_b_val,
    input  wire  [WIDTH-1:0]       i_next,
    input  wire  [WIDTH-1:0]       i_rd_a,
    input  wire  [WIDTH-1:0]       i_rd_b,
    input  wire                    i_seen,
    output logic [WIDTH-1:0]       o_elem,
    output logic [WIDTH-1:0]       o_rd_a,
    output logic [WIDTH-1:0]       o_rd_b,
    output logic                   o_seen
);
    import asbe_pkg::*;

    localparam logic [POS_W-1:0] MY_POS = POS_W'(INDEX);

    logic [WIDTH-1:0] r_elem;
    logic [WIDTH-1:0] n_elem;
    logic             live;
    logic             match;

    // Only positions below the count take part in a search
    assign live   = MY_POS < i_cmd.count;
    assign match  = live && (r_elem == i_val);
    assign o_seen = i_seen | match;

    // Read buses: OR in this element where it is the selected one
    assign o_rd_a = i_rd_a | ((i_cmd.sel_a == MY_POS) ? r_elem : '0);
    assign o_rd_b = i_rd_b | ((i_cmd.ib == MY_POS) ? r_elem : '0);
    assign o_elem = r_elem;

    always_comb begin
        n_elem = r_elem;
        unique case (i_cmd.kind)
            CK_NONE: begin
                n_elem = r_elem;
            end
            CK_PUSH: begin
                if (MY_POS == i_cmd.count) begin
                    n_elem = i_val;
                end
            end
            CK_PUT: begin
                if (MY_POS == i_cmd.ia) begin
                    n_elem = i_val;
                end
            end
            CK_SWAP: begin
                if (MY_POS == i_cmd.ia) begin
                    n_elem = i_b_val;
                end else if (MY_POS == i_cmd.ib) begin
                    n_elem = i_a_val;
                end
            end
            CK_REM_AT: begin
                if (MY_POS >= i_cmd.ia) begin
                    n_elem = i_next;
                end
            end
            CK_REM_VAL: begin
                // at and above the first match, close the gap
                if (o_seen) begin
                    n_elem = i_next;
                end
            end
            default: begin
                n_elem = r_elem;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_elem <= n_elem;
    end

endmodule

`default_nettype wire

// ===== rtl/array_stack_bag_engine.sv =====
// Stack/bag engine over a fixed row of DEPTH element cells with a fill count.
// A request is taken when start is high and busy is low; its single response
// appears on o_rsp, marked by o_done, after the execute state registers it,
// and o_done is high for one cycle only, since the receiver cannot stall. busy
// is high in the execute state, so no new request is taken while one executes;
// the response register lets the next request in while a response is on show.
// In the execute cycle every cell compares, reads, writes or takes its right
// neighbor's element at once, so compaction after a removal and the search
// for the first match both finish within that execute cycle. Push on a full
// store gives status full and no change; bad positions, empty-store reads
// and unknown ops give status error and no change.

`default_nettype none

module array_stack_bag_engine #(
    parameter int DEPTH = asbe_pkg::DEPTH_DEF,
    parameter int WIDTH = asbe_pkg::WIDTH_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    output logic                busy,
    input  asbe_pkg::t_req      i_req,
    output logic                o_done,
    output asbe_pkg::t_rsp      o_rsp
);
    import asbe_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [3:0]        r_op;
    logic [WIDTH-1:0]  r_val;
    logic [7:0]        r_ia;
    logic [7:0]        r_ib;
    logic              r_done;
    t_rsp              r_rsp;
    t_rsp              n_rsp;

    t_cell_cmd         cmd;
    logic [POS_W-1:0]  count_pos;
    logic [POS_W-1:0]  ia_pos;
    logic [POS_W-1:0]  ib_pos;
    logic              empty;
    logic              full;
    logic              ia_ok;
    logic              ib_ok;

    // Chains along the cell row
    logic [WIDTH-1:0]  elem   [DEPTH];
    logic [WIDTH-1:0]  rd_a   [DEPTH+1];
    logic [WIDTH-1:0]  rd_b   [DEPTH+1];
    logic              seen   [DEPTH+1];
    logic signed [WIDTH-1:0] rd_s;

    assign busy   = (r_state == S_EXEC);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    assign count_pos = POS_W'(r_count);
    assign ia_pos    = POS_W'(r_ia);
    assign ib_pos    = POS_W'(r_ib);
    assign empty     = (r_count == '0);
    assign full      = (r_count == CNT_W'(DEPTH));
    assign ia_ok     = ia_pos < count_pos;
    assign ib_ok     = ib_pos < count_pos;

    assign rd_a[0] = '0;
    assign rd_b[0] = '0;
    assign seen[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        // last cell has no right neighbor; it just keeps its own element
        logic [WIDTH-1:0] next_elem;
        if (g == DEPTH - 1) begin : g_last
            assign next_elem = elem[g];
        end else begin : g_mid
            assign next_elem = elem[g+1];
        end

        asbe_cell #(
            .WIDTH (WIDTH),
            .INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cmd),
            .i_val   (r_val),
            .i_a_val (rd_a[DEPTH]),
            .i_b_val (rd_b[DEPTH]),
            .i_next  (next_elem),
            .i_rd_a  (rd_a[g]),
            .i_rd_b  (rd_b[g]),
            .i_seen  (seen[g]),
            .o_elem  (elem[g]),
            .o_rd_a  (rd_a[g+1]),
            .o_rd_b  (rd_b[g+1]),
            .o_seen  (seen[g+1])
        );
    end

    // sign-extend or trim the selected element to the 32-bit result field
    assign rd_s = $signed(rd_a[DEPTH]);

    // Execute-cycle decode: status, cell action and new count
    always_comb begin
        cmd.kind  = CK_NONE;
        cmd.count = count_pos;
        cmd.ia    = ia_pos;
        cmd.ib    = ib_pos;
        // top reads the element below the count; everything else reads index_a
        cmd.sel_a = (r_op == OP_TOP) ? (count_pos - POS_W'(1)) : ia_pos;

        n_count           = r_count;
        n_rsp.read_value  = '0;
        n_rsp.found       = 1'b0;
        n_rsp.status      = ST_OK;

        unique case (r_op)
            OP_PUSH: begin
                if (full) begin
                    n_rsp.status = ST_FULL;
                end else begin
                    cmd.kind = CK_PUSH;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            OP_POP: begin
                if (empty) begin
                    n_rsp.status = ST_ERR;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            OP_TOP: begin
                if (empty) begin
                    n_rsp.status = ST_ERR;
                end else begin
                    n_rsp.read_value = 32'(rd_s);
                end
            end
            OP_GET: begin
                if (!ia_ok) begin
                    n_rsp.status = ST_ERR;
                end else begin
                    n_rsp.read_value = 32'(rd_s);
                end
            end
            OP_PUT: begin
                if (!ia_ok) begin
                    n_rsp.status = ST_ERR;
                end else begin
                    cmd.kind = CK_PUT;
                end
            end
            OP_SWAP: begin
                if (!ia_ok || !ib_ok) begin
                    n_rsp.status = ST_ERR;
                end else begin
                    cmd.kind = CK_SWAP;
                end
            end
            OP_REMOVE_AT: begin
                if (!ia_ok) begin
                    n_rsp.status = ST_ERR;
                end else begin
                    cmd.kind = CK_REM_AT;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            OP_CONTAINS: begin
                if (empty) begin
                    n_rsp.status = ST_ERR;
                end else begin
                    n_rsp.found = seen[DEPTH];
                end
            end
            OP_REMOVE_VALUE: begin
                if (empty) begin
                    n_rsp.status = ST_ERR;
                end else begin
                    n_rsp.found = seen[DEPTH];
                    if (seen[DEPTH]) begin
                        cmd.kind = CK_REM_VAL;
                        n_count  = r_count - CNT_W'(1);
                    end
                end
            end
            default: begin
                n_rsp.status = ST_ERR;
            end
        endcase

        // cells stay put outside the execute cycle
        if (r_state != S_EXEC) begin
            cmd.kind = CK_NONE;
        end

        n_rsp.count_after = 9'(n_count);
        n_rsp.is_empty    = (n_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op    <= i_req.op;
                        r_val   <= WIDTH'(i_req.item_value);
                        r_ia    <= i_req.index_a;
                        r_ib    <= i_req.index_b;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_count <= n_count;
                    r_rsp   <= n_rsp;
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
